[rtl/core/real_time_counter_with_compare_defines.svh]
// assertion helpers for the rtl core
`ifndef REAL_TIME_COUNTER_WITH_COMPARE_DEFINES_SVH
`define REAL_TIME_COUNTER_WITH_COMPARE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcc assertion failed");

// next-cycle implication, checked outside reset
`define RTCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcc assertion failed");

`endif

[rtl/core/rtcc_pkg.sv]
`timescale 1ns / 1ps

package rtcc_pkg;

    localparam int unsigned FIELD_W   = 24;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned APB_W     = 32;

    // enable mask bit positions
    localparam int unsigned EN_OVF_BIT = 0;
    localparam int unsigned EN_CMP_BIT = 1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_START   = 3'd0,
        REG_STOP    = 3'd1,
        REG_CMP_EVT = 3'd2,
        REG_OVF_EVT = 3'd3,
        REG_EN_SET  = 3'd4,
        REG_EN_CLR  = 3'd5,
        REG_COUNTER = 3'd6,
        REG_CMP_VAL = 3'd7
    } t_reg_idx;

    // configuration register index
    localparam logic [0:0] CFG_PRESCALE = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   reg_index;
        logic [FIELD_W-1:0] write_value;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] read_value;
        logic               irq;
        logic               compare_flag;
        logic               overflow_flag;
    } t_result;

endpackage

[rtl/core/rtcc_cfg.sv]
`timescale 1ns / 1ps

module rtcc_cfg import rtcc_pkg::*; #(
    parameter int unsigned PRESCALE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready,
    output logic [PRESCALE_BITS-1:0] o_prescale_divider
);

    logic [PRESCALE_BITS-1:0] r_div;
    logic [PRESCALE_BITS-1:0] n_div;
    logic                     sel_div;

    assign sel_div = (paddr[ADDR_W-1] == CFG_PRESCALE);
    assign pready  = 1'b1;

    always_comb begin
        n_div = r_div;
        if (psel && penable && pwrite && sel_div) begin
            // register field is 12 bits, then fitted to the prescaler width
            n_div = PRESCALE_BITS'(pwdata[CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
        end else begin
            r_div <= n_div;
        end
    end

    assign prdata             = sel_div ? APB_W'(r_div) : '0;
    assign o_prescale_divider = r_div;

endmodule

[rtl/core/rtcc_in_stage.sv]
`timescale 1ns / 1ps

module rtcc_in_stage import rtcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // hold the word only while the core cannot take it
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/rtcc_core.sv]
`timescale 1ns / 1ps
`include "real_time_counter_with_compare_defines.svh"

module rtcc_core import rtcc_pkg::*; #(
    parameter int unsigned COUNTER_BITS  = 24,
    parameter int unsigned PRESCALE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [PRESCALE_BITS-1:0] i_prescale_divider,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_item                    i_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_result                  o_result
);

    logic                     r_running,  n_running;
    logic [PRESCALE_BITS-1:0] r_psc,      n_psc;
    logic [COUNTER_BITS-1:0]  r_cnt,      n_cnt;
    logic [COUNTER_BITS-1:0]  r_cmp_val,  n_cmp_val;
    logic                     r_cmp_flag, n_cmp_flag;
    logic                     r_ovf_flag, n_ovf_flag;
    logic [1:0]               r_en,       n_en;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_res,      n_res;

    logic                     pass;
    logic [COUNTER_BITS-1:0]  cnt_inc;
    logic [FIELD_W-1:0]       rd;
    logic [1:0]               wmask;

    assign pass    = i_valid && (!r_out_valid || !i_stall);
    assign o_stall = i_valid && !pass;
    assign cnt_inc = COUNTER_BITS'(r_cnt + 1'b1);
    assign wmask   = i_item.write_value[1:0];

    always_comb begin
        n_running  = r_running;
        n_psc      = r_psc;
        n_cnt      = r_cnt;
        n_cmp_val  = r_cmp_val;
        n_cmp_flag = r_cmp_flag;
        n_ovf_flag = r_ovf_flag;
        n_en       = r_en;
        rd         = '0;

        case (i_item.op)
            OP_TICK: begin
                if (r_running) begin
                    if (r_psc >= i_prescale_divider) begin
                        n_psc = '0;
                        n_cnt = cnt_inc;
                        if (cnt_inc == '0) begin
                            n_ovf_flag = 1'b1;
                        end
                        if (cnt_inc == r_cmp_val) begin
                            n_cmp_flag = 1'b1;
                        end
                    end else begin
                        n_psc = PRESCALE_BITS'(r_psc + 1'b1);
                    end
                end
            end
            OP_READ: begin
                case (i_item.reg_index)
                    REG_CMP_EVT: rd = FIELD_W'(r_cmp_flag);
                    REG_OVF_EVT: rd = FIELD_W'(r_ovf_flag);
                    REG_EN_SET:  rd = FIELD_W'(r_en);
                    REG_EN_CLR:  rd = FIELD_W'(r_en);
                    REG_COUNTER: rd = FIELD_W'(r_cnt);
                    REG_CMP_VAL: rd = FIELD_W'(r_cmp_val);
                    default:     rd = '0;
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_index)
                    REG_START:   if (i_item.write_value[0]) n_running = 1'b1;
                    REG_STOP:    if (i_item.write_value[0]) n_running = 1'b0;
                    REG_CMP_EVT: n_cmp_flag = i_item.write_value[0];
                    REG_OVF_EVT: n_ovf_flag = i_item.write_value[0];
                    REG_EN_SET:  n_en = r_en | wmask;
                    REG_EN_CLR:  n_en = r_en & ~wmask;
                    REG_CMP_VAL: n_cmp_val = COUNTER_BITS'(i_item.write_value);
                    default:     n_en = r_en;
                endcase
            end
            default: rd = '0;
        endcase

        n_res.read_value    = rd;
        n_res.compare_flag  = n_cmp_flag;
        n_res.overflow_flag = n_ovf_flag;
        n_res.irq           = (n_ovf_flag && n_en[EN_OVF_BIT])
                           || (n_cmp_flag && n_en[EN_CMP_BIT]);

        n_out_valid = r_out_valid;
        if (pass) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_psc       <= '0;
            r_cnt       <= '0;
            r_cmp_val   <= '0;
            r_cmp_flag  <= 1'b0;
            r_ovf_flag  <= 1'b0;
            r_en        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pass) begin
                r_running  <= n_running;
                r_psc      <= n_psc;
                r_cnt      <= n_cnt;
                r_cmp_val  <= n_cmp_val;
                r_cmp_flag <= n_cmp_flag;
                r_ovf_flag <= n_ovf_flag;
                r_en       <= n_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    `RTCC_ASSERT_IMP(a_flags_track, i_clk, i_rst_n, r_out_valid,
        (r_res.compare_flag == r_cmp_flag) && (r_res.overflow_flag == r_ovf_flag))
    `RTCC_ASSERT_NXT(a_stopped_holds, i_clk, i_rst_n,
        pass && (i_item.op == OP_TICK) && !r_running, $stable(r_cnt) && $stable(r_psc))
    `RTCC_ASSERT_NXT(a_prescale_holds_count, i_clk, i_rst_n,
        pass && (i_item.op == OP_TICK) && (r_psc < i_prescale_divider), $stable(r_cnt))
    `RTCC_ASSERT_NXT(a_rd_zero, i_clk, i_rst_n,
        pass && (i_item.op != OP_READ), r_res.read_value == '0)

endmodule

[rtl/core/real_time_counter_with_compare.sv]
// a word is registered in the entry register on entry and its result is registered in the core's result register,
//   which offers it on the result channel until the result side takes it
// throughput: one word per cycle, held back only when the result side stalls
// reset: synchronous active-low i_rst_n stops the counter and clears prescale count,
//   counter, compare value, event flags, interrupt enables and the prescale divider
`timescale 1ns / 1ps

module real_time_counter_with_compare import rtcc_pkg::*; #(
    parameter int unsigned COUNTER_BITS  = 24,
    parameter int unsigned PRESCALE_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register bus
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [IDX_W-1:0]   i_reg_index,
    input  logic [FIELD_W-1:0] i_write_value,
    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_read_value,
    output logic               o_irq,
    output logic               o_compare_flag_out,
    output logic               o_overflow_flag_out
);

    // prescale divider from the register bus; the user must keep it stable while words are in flight (not enforced)
    logic [PRESCALE_BITS-1:0] prescale_divider;

    // entry register to core
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    stage_stall;
    t_result result;

    assign in_item.op          = i_op;
    assign in_item.reg_index   = i_reg_index;
    assign in_item.write_value = i_write_value;

    rtcc_cfg #(
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_prescale_divider (prescale_divider)
    );

    // entry register: takes a new word whenever it is empty or the core moves the held one on
    rtcc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_stall (stage_stall),
        .o_item  (stage_item)
    );

    // core: timer state, single-pass update and result register
    rtcc_core #(
        .COUNTER_BITS  (COUNTER_BITS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_prescale_divider (prescale_divider),
        .i_valid            (stage_valid),
        .o_stall            (stage_stall),
        .i_item             (stage_item),
        .o_valid            (o_out_valid),
        .i_stall            (i_out_stall),
        .o_result           (result)
    );

    assign o_read_value        = result.read_value;
    assign o_irq               = result.irq;
    assign o_compare_flag_out  = result.compare_flag;
    assign o_overflow_flag_out = result.overflow_flag;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rtcc_pkg::*;

    // op code the block must treat as a no-op
    localparam logic [OP_W-1:0]   OP_SPARE      = 2'd3;
    localparam logic [ADDR_W-1:0] PRESCALE_ADDR = ADDR_W'(4 * CFG_PRESCALE);
    localparam int                ITEM_TARGET   = 1350;
    localparam int                CYCLE_LIMIT   = 400000;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [APB_W-1:0]   pwdata        = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_op          = '0;
    logic [IDX_W-1:0]   i_reg_index   = '0;
    logic [FIELD_W-1:0] i_write_value = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [FIELD_W-1:0] o_read_value;
    logic               o_irq;
    logic               o_compare_flag_out;
    logic               o_overflow_flag_out;

    real_time_counter_with_compare u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_reg_index        (i_reg_index),
        .i_write_value      (i_write_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_read_value       (o_read_value),
        .o_irq              (o_irq),
        .o_compare_flag_out (o_compare_flag_out),
        .o_overflow_flag_out(o_overflow_flag_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // predicted timer state, at reset values
    logic               run_q      = 1'b0;
    logic [CFG_W-1:0]   psc_div    = '0;
    logic [CFG_W-1:0]   psc_cnt_q  = '0;
    logic [FIELD_W-1:0] cnt_q      = '0;
    logic [FIELD_W-1:0] cmp_val_q  = '0;
    logic               cmp_flag_q = 1'b0;
    logic               ovf_flag_q = 1'b0;
    logic [1:0]         irq_en_q   = '0;

    t_item   pending_words[$];
    t_result expected_results[$];
    int      mismatches = 0;
    int      cycle_cnt  = 0;

    // applies one word to the predicted state and returns the result it gives
    function automatic t_result rtc_step(input t_item w);
        t_result r;
        r = '0;
        case (w.op)
            OP_TICK: begin
                if (run_q) begin
                    if (psc_cnt_q >= psc_div) begin
                        psc_cnt_q = '0;
                        cnt_q     = cnt_q + 1'b1;
                        if (cnt_q == '0)
                            ovf_flag_q = 1'b1;
                        if (cnt_q == cmp_val_q)
                            cmp_flag_q = 1'b1;
                    end else begin
                        psc_cnt_q = psc_cnt_q + 1'b1;
                    end
                end
            end
            OP_READ: begin
                case (w.reg_index)
                    REG_CMP_EVT: r.read_value = FIELD_W'(cmp_flag_q);
                    REG_OVF_EVT: r.read_value = FIELD_W'(ovf_flag_q);
                    REG_EN_SET,
                    REG_EN_CLR:  r.read_value = FIELD_W'(irq_en_q);
                    REG_COUNTER: r.read_value = cnt_q;
                    REG_CMP_VAL: r.read_value = cmp_val_q;
                    default:     r.read_value = '0;
                endcase
            end
            OP_WRITE: begin
                case (w.reg_index)
                    REG_START: begin
                        if (w.write_value[0])
                            run_q = 1'b1;
                    end
                    REG_STOP: begin
                        if (w.write_value[0])
                            run_q = 1'b0;
                    end
                    REG_CMP_EVT: cmp_flag_q = w.write_value[0];
                    REG_OVF_EVT: ovf_flag_q = w.write_value[0];
                    REG_EN_SET:  irq_en_q   = irq_en_q | w.write_value[1:0];
                    REG_EN_CLR:  irq_en_q   = irq_en_q & ~w.write_value[1:0];
                    REG_CMP_VAL: cmp_val_q  = w.write_value;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.irq           = (ovf_flag_q && irq_en_q[EN_OVF_BIT]) ||
                          (cmp_flag_q && irq_en_q[EN_CMP_BIT]);
        r.compare_flag  = cmp_flag_q;
        r.overflow_flag = ovf_flag_q;
        return r;
    endfunction

    function automatic t_item make_word(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [FIELD_W-1:0] val);
        t_item w;
        w.op          = op;
        w.reg_index   = idx;
        w.write_value = val;
        return w;
    endfunction

    // mostly ticks, with reads, writes and the odd spare op code
    function automatic t_item random_word();
        t_item       w;
        int unsigned sel;
        sel           = $urandom_range(0, 99);
        w.reg_index   = IDX_W'($urandom_range(0, 7));
        w.write_value = FIELD_W'($urandom);
        if (sel < 50) begin
            w.op = OP_TICK;
        end else if (sel < 68) begin
            w.op = OP_READ;
        end else if (sel < 96) begin
            w.op = OP_WRITE;
            case (w.reg_index)
                REG_START: w.write_value[0] = ($urandom_range(0, 4) != 0);
                REG_STOP:  w.write_value[0] = ($urandom_range(0, 9) < 3);
                REG_CMP_VAL: begin
                    // aim just ahead of the counter so compare events happen
                    if ($urandom_range(0, 9) < 6)
                        w.write_value = cnt_q + FIELD_W'($urandom_range(1, 12));
                end
                default: ;
            endcase
        end else begin
            w.op = OP_SPARE;
        end
        return w;
    endfunction

    // per-word wait, with runs of back-to-back words mixed in
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // writes the prescale divider and reads it back
    task automatic set_prescale(input logic [CFG_W-1:0] div);
        logic [APB_W-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PRESCALE_ADDR;
        pwdata  <= APB_W'(div);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psc_div = div;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_W'(div)) begin
            $error("prescale_divider: expected %0h, got %0h", div, rd);
            mismatches++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // input side: one word in flight, random gap after each
    t_item cur_word;
    int    tx_gap  = 0;
    int    tx_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(rtc_step(cur_word));
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    i_op          <= cur_word.op;
                    i_reg_index   <= cur_word.reg_index;
                    i_write_value <= cur_word.write_value;
                    i_in_valid    <= 1'b1;
                    tx_gap = draw_wait(tx_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare against the oldest prediction, random stalls
    t_result want;
    int      rx_stall = 0;
    int      rx_calm  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: read_value %0h", o_read_value);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_value", want.read_value, o_read_value);
                    check_field("irq", FIELD_W'(want.irq), FIELD_W'(o_irq));
                    check_field("compare_flag_out", FIELD_W'(want.compare_flag),
                                FIELD_W'(o_compare_flag_out));
                    check_field("overflow_flag_out", FIELD_W'(want.overflow_flag),
                                FIELD_W'(o_overflow_flag_out));
                end
                rx_stall = draw_wait(rx_calm);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    int unsigned div_plan[6] = '{0, 4095, 1, 7, 2, 0};

    initial begin
        int left;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset divider
        pending_words.push_back(make_word(OP_TICK, REG_START, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_SPARE, REG_CMP_VAL, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_READ, REG_COUNTER, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_START, 24'hFFFFFE));
        pending_words.push_back(make_word(OP_TICK, REG_COUNTER, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_START, 24'h000001));
        pending_words.push_back(make_word(OP_TICK, REG_STOP, 24'h000000));
        pending_words.push_back(make_word(OP_TICK, REG_EN_SET, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_WRITE, REG_COUNTER, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_READ, REG_COUNTER, 24'hFFFFFF));
        // compare value equal to the counter must not raise the event
        pending_words.push_back(make_word(OP_WRITE, REG_CMP_VAL, 24'h000002));
        pending_words.push_back(make_word(OP_READ, REG_CMP_EVT, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_CMP_VAL, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_READ, REG_CMP_VAL, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_CMP_VAL, 24'h000003));
        pending_words.push_back(make_word(OP_TICK, REG_CMP_VAL, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_EN_SET, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_READ, REG_EN_CLR, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_OVF_EVT, 24'h000001));
        pending_words.push_back(make_word(OP_READ, REG_OVF_EVT, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_CMP_EVT, 24'hFFFFFE));
        pending_words.push_back(make_word(OP_WRITE, REG_EN_CLR, 24'h000001));
        pending_words.push_back(make_word(OP_READ, REG_EN_SET, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_OVF_EVT, 24'h000000));
        pending_words.push_back(make_word(OP_WRITE, REG_STOP, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_TICK, REG_START, 24'h000000));
        pending_words.push_back(make_word(OP_READ, REG_START, 24'hFFFFFF));
        pending_words.push_back(make_word(OP_READ, REG_STOP, 24'hFFFFFF));
        wait_drained();

        // slowest divider: prescale count climbs without the counter moving
        set_prescale(12'hFFF);
        pending_words.push_back(make_word(OP_WRITE, REG_START, 24'h000001));
        repeat (30)
            pending_words.push_back(make_word(OP_TICK, IDX_W'($urandom), FIELD_W'($urandom)));
        pending_words.push_back(make_word(OP_READ, REG_COUNTER, 24'h000000));
        wait_drained();

        // divider lowered under the prescale count: next tick advances at once
        set_prescale(12'd3);
        pending_words.push_back(make_word(OP_TICK, REG_CMP_VAL, 24'h000000));
        pending_words.push_back(make_word(OP_READ, REG_COUNTER, 24'h000000));
        repeat (4)
            pending_words.push_back(make_word(OP_TICK, REG_CMP_VAL, 24'h000000));
        pending_words.push_back(make_word(OP_READ, REG_COUNTER, 24'h000000));
        wait_drained();

        // random phases, one divider setting each
        foreach (div_plan[p]) begin
            if (p == 3)
                set_prescale(CFG_W'($urandom_range(0, 15)));
            else
                set_prescale(CFG_W'(div_plan[p]));
            left = ITEM_TARGET / $size(div_plan);
            while (left > 0) begin
                n = $urandom_range(5, 60);
                if (n > left)
                    n = left;
                repeat (n)
                    pending_words.push_back(random_word());
                left -= n;
                // now and then hold the input back until every result is in
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
